// ===== rtl/dsck_pkg.sv =====
// ============================================================================
// dsck_pkg
// Shared types, codes and helper functions for the dose schedule clock keeper.
// ============================================================================
package dsck_pkg;

  // Input mode codes
  localparam logic [2:0] MODE_READ   = 3'd0;
  localparam logic [2:0] MODE_ADJUST = 3'd1;
  localparam logic [2:0] MODE_SAMPLE = 3'd2;
  localparam logic [2:0] MODE_SORT   = 3'd3;
  localparam logic [2:0] MODE_LOAD   = 3'd4;

  // Field codes
  localparam logic [4:0] FC_SEC        = 5'd0;
  localparam logic [4:0] FC_MIN        = 5'd1;
  localparam logic [4:0] FC_HOUR       = 5'd2;
  localparam logic [4:0] FC_DAY        = 5'd3;
  localparam logic [4:0] FC_MONTH      = 5'd4;
  localparam logic [4:0] FC_YEAR       = 5'd5;
  localparam logic [4:0] FC_WEEK       = 5'd6;
  localparam logic [4:0] FC_DOSE_FIRST = 5'd7;
  localparam logic [4:0] FC_DOSE_LAST  = 5'd14;
  localparam logic [4:0] FC_REMAIN     = 5'd15;
  localparam logic [4:0] FC_TOTAL      = 5'd16;

  // Field limits
  localparam logic [7:0] SEC_MAX       = 8'd59;
  localparam logic [7:0] MIN_MAX       = 8'd59;
  localparam logic [7:0] HOUR_MAX      = 8'd23;
  localparam logic [7:0] MONTH_MAX     = 8'd12;
  localparam logic [7:0] YEAR_MAX      = 8'd99;
  localparam logic [7:0] WEEK_MAX      = 8'd7;
  localparam logic [7:0] NO_DOSE_HOUR  = 8'd24;
  localparam logic [7:0] LOW_ZERO      = 8'd0;
  localparam logic [7:0] LOW_ONE       = 8'd1;
  localparam logic [7:0] DAY_LONG      = 8'd31;
  localparam logic [7:0] DAY_SHORT     = 8'd30;
  localparam logic [7:0] DAY_FEB_LEAP  = 8'd29;
  localparam logic [7:0] DAY_FEB       = 8'd28;
  localparam logic [3:0] MONTH_FEB     = 4'd2;
  localparam logic [3:0] MONTH_APR     = 4'd4;
  localparam logic [3:0] MONTH_JUN     = 4'd6;
  localparam logic [3:0] MONTH_SEP     = 4'd9;
  localparam logic [3:0] MONTH_NOV     = 4'd11;
  localparam logic [7:0] MAX_PILLS     = 8'd99;
  localparam logic [7:0] UNKNOWN_VALUE = 8'd255;
  localparam logic [11:0] TABLE_EMPTY  = 12'd2400;
  localparam logic [11:0] HOUR_SCALE   = 12'd100;

  localparam int NUM_DOSES   = 4;
  localparam int DOSE_IDX_W  = $clog2(NUM_DOSES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] field_code;
    logic       step_down;
    logic [6:0] rtc_year;
    logic [3:0] rtc_month;
    logic [4:0] rtc_day;
    logic [2:0] rtc_week;
    logic [4:0] rtc_hour;
    logic [5:0] rtc_minute;
    logic [5:0] rtc_second;
    logic       alarm_playing;
    logic [7:0] count_value;
  } dsck_in_t;

  typedef struct packed {
    logic [7:0]  field_value;
    logic        remind;
    logic        missed_dose;
    logic [11:0] schedule_entry;
    logic        last;
  } dsck_out_t;

  typedef enum logic [2:0] {
    OP_READ,
    OP_ADJUST,
    OP_SAMPLE,
    OP_SORT,
    OP_LOAD
  } dsck_op_t;

  typedef struct packed {
    dsck_op_t   op;
    logic [4:0] field_code;
    logic       step_down;
    logic [6:0] rtc_year;
    logic [3:0] rtc_month;
    logic [4:0] rtc_day;
    logic [2:0] rtc_week;
    logic [4:0] rtc_hour;
    logic [5:0] rtc_minute;
    logic [5:0] rtc_second;
    logic       alarm_playing;
    logic [7:0] count_value;
  } dsck_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dsck_qstat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_L1,
    BK_L2,
    BK_L3,
    BK_E1,
    BK_E2,
    BK_E3
  } dsck_state_t;

  function automatic logic [7:0] wrap_step(input logic [7:0] v, input logic [7:0] lo,
                                           input logic [7:0] hi, input logic down);
    logic [7:0] r;
    if (down) begin
      r = (v <= lo) ? hi : v - 8'd1;
    end else begin
      r = (v >= hi) ? lo : v + 8'd1;
    end
    return r;
  endfunction

  function automatic logic [7:0] count_step(input logic [7:0] v, input logic down);
    logic [7:0] r;
    if (down) begin
      r = (v != 8'd0) ? v - 8'd1 : 8'd0;
    end else begin
      r = (v < MAX_PILLS) ? v + 8'd1 : MAX_PILLS;
    end
    return r;
  endfunction

  function automatic logic [11:0] pack_time(input logic [4:0] h, input logic [5:0] m);
    logic [11:0] hh;
    hh = {7'd0, h};
    return 12'(hh * HOUR_SCALE) + {6'd0, m};
  endfunction

endpackage

// ===== rtl/dsck_front.sv =====
// ============================================================================
// dsck_front
// Accepts input transactions, decodes the mode and queues valid commands.
// ============================================================================
module dsck_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dsck_pkg::dsck_in_t    in_data,
  input  dsck_pkg::dsck_qstat_t q_stat,
  output logic                  push,
  output dsck_pkg::dsck_cmd_t   push_cmd
);

  logic             mode_ok;
  dsck_pkg::dsck_op_t op;
  logic             seen_r;
  logic             seen_nxt;

  always_comb begin
    mode_ok = 1'b1;
    op      = dsck_pkg::OP_READ;
    case (in_data.mode) inside
      dsck_pkg::MODE_READ:   op = dsck_pkg::OP_READ;
      dsck_pkg::MODE_ADJUST: op = dsck_pkg::OP_ADJUST;
      dsck_pkg::MODE_SAMPLE: op = dsck_pkg::OP_SAMPLE;
      dsck_pkg::MODE_SORT:   op = dsck_pkg::OP_SORT;
      dsck_pkg::MODE_LOAD:   op = dsck_pkg::OP_LOAD;
      default:               mode_ok = 1'b0;
    endcase
  end

  // Unused modes are taken and dropped.
  assign in_ready = !q_stat.full && seen_r;
  assign push     = in_valid && in_ready && mode_ok;

  always_comb begin
    push_cmd.op            = op;
    push_cmd.field_code    = in_data.field_code;
    push_cmd.step_down     = in_data.step_down;
    push_cmd.rtc_year      = in_data.rtc_year;
    push_cmd.rtc_month     = in_data.rtc_month;
    push_cmd.rtc_day       = in_data.rtc_day;
    push_cmd.rtc_week      = in_data.rtc_week;
    push_cmd.rtc_hour      = in_data.rtc_hour;
    push_cmd.rtc_minute    = in_data.rtc_minute;
    push_cmd.rtc_second    = in_data.rtc_second;
    push_cmd.alarm_playing = in_data.alarm_playing;
    push_cmd.count_value   = in_data.count_value;
  end

  // Hold ready low out of reset until seen_r has been set.
  assign seen_nxt = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

endmodule

// ===== rtl/dsck_cmd_queue.sv =====
// ============================================================================
// dsck_cmd_queue
// Short command FIFO between the front end and the execution back end.
// ============================================================================
module dsck_cmd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dsck_pkg::dsck_cmd_t   push_cmd,
  input  logic                  pop,
  output dsck_pkg::dsck_cmd_t   pop_cmd,
  output dsck_pkg::dsck_qstat_t q_stat
);

  dsck_pkg::dsck_cmd_t             mem [dsck_pkg::QUEUE_DEPTH];
  logic [dsck_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [dsck_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [dsck_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                            do_push, do_pop;

  assign q_stat.full  = (count_r == dsck_pkg::QCNT_W'(dsck_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_cmd      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == dsck_pkg::QPTR_W'(dsck_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == dsck_pkg::QPTR_W'(dsck_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/dsck_exec.sv =====
// ============================================================================
// dsck_exec
// Back end: holds clock, dose and count state, executes queued commands and
// drives the registered result channel.
// ============================================================================
module dsck_exec (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dsck_pkg::dsck_qstat_t q_stat,
  input  dsck_pkg::dsck_cmd_t   q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dsck_pkg::dsck_out_t   out_data
);

  localparam int ND = dsck_pkg::NUM_DOSES;

  dsck_pkg::dsck_state_t state_r, state_nxt;

  logic [6:0]  clock_year_r,   clock_year_nxt;
  logic [3:0]  clock_month_r,  clock_month_nxt;
  logic [4:0]  clock_day_r,    clock_day_nxt;
  logic [2:0]  clock_week_r,   clock_week_nxt;
  logic [4:0]  clock_hour_r,   clock_hour_nxt;
  logic [5:0]  clock_minute_r, clock_minute_nxt;
  logic [5:0]  clock_second_r, clock_second_nxt;
  logic [4:0]  prev_hour_r,    prev_hour_nxt;
  logic [5:0]  prev_minute_r,  prev_minute_nxt;
  logic [4:0]  dose_hour_r   [ND];
  logic [4:0]  dose_hour_nxt [ND];
  logic [5:0]  dose_minute_r   [ND];
  logic [5:0]  dose_minute_nxt [ND];
  logic [11:0] table_r   [ND];
  logic [11:0] table_nxt [ND];
  logic [7:0]  total_r,  total_nxt;
  logic [7:0]  remain_r, remain_nxt;
  logic        out_valid_r, out_valid_nxt;
  dsck_pkg::dsck_out_t out_data_r, out_data_nxt;

  logic        out_free;
  logic        issue;
  logic        is_dose;
  logic [4:0]  didx;
  logic [dsck_pkg::DOSE_IDX_W-1:0] dk;
  logic [7:0]  day_lim;
  logic [7:0]  rd_val;
  logic [7:0]  adj_val;
  logic [7:0]  load_val;
  logic [11:0] cur_time, prev_time;
  logic        now_match, prev_match;

  assign out_free  = !out_valid_r || out_ready;
  assign issue     = (state_r == dsck_pkg::BK_IDLE) && !q_stat.empty && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state: sort sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dsck_pkg::BK_IDLE: if (issue && q_cmd.op == dsck_pkg::OP_SORT) state_nxt = dsck_pkg::BK_L1;
      dsck_pkg::BK_L1:   state_nxt = dsck_pkg::BK_L2;
      dsck_pkg::BK_L2:   state_nxt = dsck_pkg::BK_L3;
      dsck_pkg::BK_L3:   if (out_free) state_nxt = dsck_pkg::BK_E1;
      dsck_pkg::BK_E1:   if (out_free) state_nxt = dsck_pkg::BK_E2;
      dsck_pkg::BK_E2:   if (out_free) state_nxt = dsck_pkg::BK_E3;
      dsck_pkg::BK_E3:   if (out_free) state_nxt = dsck_pkg::BK_IDLE;
      default:           state_nxt = dsck_pkg::BK_IDLE;
    endcase
  end

  // Field decode, read and adjust values
  assign is_dose = (q_cmd.field_code >= dsck_pkg::FC_DOSE_FIRST) &&
                   (q_cmd.field_code <= dsck_pkg::FC_DOSE_LAST);
  assign didx    = q_cmd.field_code - dsck_pkg::FC_DOSE_FIRST;
  assign dk      = didx[dsck_pkg::DOSE_IDX_W:1];

  always_comb begin
    case (clock_month_r) inside
      dsck_pkg::MONTH_APR, dsck_pkg::MONTH_JUN,
      dsck_pkg::MONTH_SEP, dsck_pkg::MONTH_NOV: day_lim = dsck_pkg::DAY_SHORT;
      dsck_pkg::MONTH_FEB: day_lim = (clock_year_r[1:0] == 2'd0) ?
                                     dsck_pkg::DAY_FEB_LEAP : dsck_pkg::DAY_FEB;
      default:             day_lim = dsck_pkg::DAY_LONG;
    endcase
  end

  always_comb begin
    rd_val  = dsck_pkg::UNKNOWN_VALUE;
    adj_val = dsck_pkg::UNKNOWN_VALUE;
    if (is_dose) begin
      if (didx[0]) begin
        rd_val  = {3'd0, dose_hour_r[dk]};
        adj_val = dsck_pkg::wrap_step(rd_val, dsck_pkg::LOW_ZERO, dsck_pkg::NO_DOSE_HOUR,
                                      q_cmd.step_down);
      end else begin
        rd_val  = {2'd0, dose_minute_r[dk]};
        adj_val = dsck_pkg::wrap_step(rd_val, dsck_pkg::LOW_ZERO, dsck_pkg::MIN_MAX,
                                      q_cmd.step_down);
      end
    end else begin
      case (q_cmd.field_code)
        dsck_pkg::FC_SEC: begin
          rd_val  = {2'd0, clock_second_r};
          adj_val = dsck_pkg::wrap_step(rd_val, dsck_pkg::LOW_ZERO, dsck_pkg::SEC_MAX,
                                        q_cmd.step_down);
        end
        dsck_pkg::FC_MIN: begin
          rd_val  = {2'd0, clock_minute_r};
          adj_val = dsck_pkg::wrap_step(rd_val, dsck_pkg::LOW_ZERO, dsck_pkg::MIN_MAX,
                                        q_cmd.step_down);
        end
        dsck_pkg::FC_HOUR: begin
          rd_val  = {3'd0, clock_hour_r};
          adj_val = dsck_pkg::wrap_step(rd_val, dsck_pkg::LOW_ZERO, dsck_pkg::HOUR_MAX,
                                        q_cmd.step_down);
        end
        dsck_pkg::FC_DAY: begin
          rd_val  = {3'd0, clock_day_r};
          adj_val = dsck_pkg::wrap_step(rd_val, dsck_pkg::LOW_ONE, day_lim, q_cmd.step_down);
        end
        dsck_pkg::FC_MONTH: begin
          rd_val  = {4'd0, clock_month_r};
          adj_val = dsck_pkg::wrap_step(rd_val, dsck_pkg::LOW_ONE, dsck_pkg::MONTH_MAX,
                                        q_cmd.step_down);
        end
        dsck_pkg::FC_YEAR: begin
          rd_val  = {1'd0, clock_year_r};
          adj_val = dsck_pkg::wrap_step(rd_val, dsck_pkg::LOW_ZERO, dsck_pkg::YEAR_MAX,
                                        q_cmd.step_down);
        end
        dsck_pkg::FC_WEEK: begin
          rd_val  = {5'd0, clock_week_r};
          adj_val = dsck_pkg::wrap_step(rd_val, dsck_pkg::LOW_ONE, dsck_pkg::WEEK_MAX,
                                        q_cmd.step_down);
        end
        dsck_pkg::FC_REMAIN: begin
          rd_val  = remain_r;
          adj_val = dsck_pkg::count_step(rd_val, q_cmd.step_down);
        end
        dsck_pkg::FC_TOTAL: begin
          rd_val  = total_r;
          adj_val = dsck_pkg::count_step(rd_val, q_cmd.step_down);
        end
        default: begin
          rd_val  = dsck_pkg::UNKNOWN_VALUE;
          adj_val = dsck_pkg::UNKNOWN_VALUE;
        end
      endcase
    end
  end

  assign load_val = (q_cmd.count_value > dsck_pkg::MAX_PILLS) ?
                    dsck_pkg::MAX_PILLS : q_cmd.count_value;

  // Match test against the table as it stands
  assign cur_time  = dsck_pkg::pack_time(q_cmd.rtc_hour, q_cmd.rtc_minute);
  assign prev_time = dsck_pkg::pack_time(clock_hour_r, clock_minute_r);

  always_comb begin
    now_match  = 1'b0;
    prev_match = 1'b0;
    for (int k = 0; k < ND; k++) begin
      if (table_r[k] == cur_time)  now_match  = 1'b1;
      if (table_r[k] == prev_time) prev_match = 1'b1;
    end
  end

  // Outputs and state updates
  always_comb begin
    clock_year_nxt   = clock_year_r;
    clock_month_nxt  = clock_month_r;
    clock_day_nxt    = clock_day_r;
    clock_week_nxt   = clock_week_r;
    clock_hour_nxt   = clock_hour_r;
    clock_minute_nxt = clock_minute_r;
    clock_second_nxt = clock_second_r;
    prev_hour_nxt    = prev_hour_r;
    prev_minute_nxt  = prev_minute_r;
    dose_hour_nxt    = dose_hour_r;
    dose_minute_nxt  = dose_minute_r;
    table_nxt        = table_r;
    total_nxt        = total_r;
    remain_nxt       = remain_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_data_nxt     = out_data_r;
    q_pop            = 1'b0;

    case (state_r)
      dsck_pkg::BK_IDLE: begin
        if (issue) begin
          q_pop        = 1'b1;
          out_data_nxt = '0;
          out_data_nxt.last = 1'b1;
          out_valid_nxt     = 1'b1;
          case (q_cmd.op)
            dsck_pkg::OP_READ: begin
              out_data_nxt.field_value = rd_val;
            end
            dsck_pkg::OP_ADJUST: begin
              out_data_nxt.field_value = adj_val;
              if (is_dose) begin
                if (didx[0]) dose_hour_nxt[dk]   = adj_val[4:0];
                else         dose_minute_nxt[dk] = adj_val[5:0];
              end else begin
                case (q_cmd.field_code)
                  dsck_pkg::FC_SEC:    clock_second_nxt = adj_val[5:0];
                  dsck_pkg::FC_MIN:    clock_minute_nxt = adj_val[5:0];
                  dsck_pkg::FC_HOUR:   clock_hour_nxt   = adj_val[4:0];
                  dsck_pkg::FC_DAY:    clock_day_nxt    = adj_val[4:0];
                  dsck_pkg::FC_MONTH:  clock_month_nxt  = adj_val[3:0];
                  dsck_pkg::FC_YEAR:   clock_year_nxt   = adj_val[6:0];
                  dsck_pkg::FC_WEEK:   clock_week_nxt   = adj_val[2:0];
                  dsck_pkg::FC_REMAIN: remain_nxt       = adj_val;
                  dsck_pkg::FC_TOTAL:  total_nxt        = adj_val;
                  default: ;
                endcase
              end
            end
            dsck_pkg::OP_SAMPLE: begin
              prev_hour_nxt    = clock_hour_r;
              prev_minute_nxt  = clock_minute_r;
              clock_year_nxt   = q_cmd.rtc_year;
              clock_month_nxt  = q_cmd.rtc_month;
              clock_day_nxt    = q_cmd.rtc_day;
              clock_week_nxt   = q_cmd.rtc_week;
              clock_hour_nxt   = q_cmd.rtc_hour;
              clock_minute_nxt = q_cmd.rtc_minute;
              clock_second_nxt = q_cmd.rtc_second;
              out_data_nxt.remind = now_match &&
                  ((clock_minute_r != q_cmd.rtc_minute) || (clock_hour_r != q_cmd.rtc_hour));
              out_data_nxt.missed_dose = prev_match && !now_match && q_cmd.alarm_playing;
            end
            dsck_pkg::OP_SORT: begin
              // load packed dose times; results come from the sort sequence
              out_valid_nxt = out_valid_r && !out_ready;
              out_data_nxt  = out_data_r;
              for (int k = 0; k < ND; k++) begin
                table_nxt[k] = dsck_pkg::pack_time(dose_hour_r[k], dose_minute_r[k]);
              end
            end
            dsck_pkg::OP_LOAD: begin
              total_nxt  = load_val;
              remain_nxt = load_val;
              out_data_nxt.field_value = load_val;
            end
            default: begin
              out_valid_nxt = out_valid_r && !out_ready;
              out_data_nxt  = out_data_r;
            end
          endcase
        end
      end
      dsck_pkg::BK_L1: begin
        if (table_r[1] < table_r[0]) begin
          table_nxt[0] = table_r[1];
          table_nxt[1] = table_r[0];
        end
        if (table_r[3] < table_r[2]) begin
          table_nxt[2] = table_r[3];
          table_nxt[3] = table_r[2];
        end
      end
      dsck_pkg::BK_L2: begin
        if (table_r[2] < table_r[0]) begin
          table_nxt[0] = table_r[2];
          table_nxt[2] = table_r[0];
        end
        if (table_r[3] < table_r[1]) begin
          table_nxt[1] = table_r[3];
          table_nxt[3] = table_r[1];
        end
      end
      dsck_pkg::BK_L3: begin
        // entry 0 is final after the second level; emit it while fixing the middle
        if (out_free) begin
          if (table_r[2] < table_r[1]) begin
            table_nxt[1] = table_r[2];
            table_nxt[2] = table_r[1];
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.schedule_entry = table_r[0];
        end
      end
      dsck_pkg::BK_E1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.schedule_entry = table_r[1];
        end
      end
      dsck_pkg::BK_E2: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.schedule_entry = table_r[2];
        end
      end
      dsck_pkg::BK_E3: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.schedule_entry = table_r[3];
          out_data_nxt.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= dsck_pkg::BK_IDLE;
      out_valid_r    <= 1'b0;
      clock_year_r   <= '0;
      clock_month_r  <= '0;
      clock_day_r    <= '0;
      clock_week_r   <= '0;
      clock_hour_r   <= '0;
      clock_minute_r <= '0;
      clock_second_r <= '0;
      prev_hour_r    <= '0;
      prev_minute_r  <= '0;
      total_r        <= '0;
      remain_r       <= '0;
      for (int k = 0; k < ND; k++) begin
        dose_hour_r[k]   <= dsck_pkg::NO_DOSE_HOUR[4:0];
        dose_minute_r[k] <= '0;
        table_r[k]       <= dsck_pkg::TABLE_EMPTY;
      end
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      clock_year_r   <= clock_year_nxt;
      clock_month_r  <= clock_month_nxt;
      clock_day_r    <= clock_day_nxt;
      clock_week_r   <= clock_week_nxt;
      clock_hour_r   <= clock_hour_nxt;
      clock_minute_r <= clock_minute_nxt;
      clock_second_r <= clock_second_nxt;
      prev_hour_r    <= prev_hour_nxt;
      prev_minute_r  <= prev_minute_nxt;
      total_r        <= total_nxt;
      remain_r       <= remain_nxt;
      dose_hour_r    <= dose_hour_nxt;
      dose_minute_r  <= dose_minute_nxt;
      table_r        <= table_nxt;
    end
  end

endmodule

// ===== rtl/dose_schedule_clock_keeper.sv =====
// ============================================================================
// dose_schedule_clock_keeper
// Calendar clock, dose schedule and pill count keeper.
// ============================================================================
// Usage:
//   Input channel in_valid/in_ready/in_data carries one command per
//   transaction; modes 5 to 7 are taken and produce no result. The result
//   channel out_valid/out_ready/out_data returns one transaction per command,
//   or four for a schedule resort (last marks the final one).
//   A single-result command passes through the command queue and the
//   result register; a resort packs the dose times, runs three compare
//   levels and emits its entries, the first alongside the last level and
//   then one entry per cycle while out_ready is high. Single-result
//   commands are taken at one per cycle while out_ready stays high; a
//   resort holds the back-end sorter and no new command issues until it ends.
//   A two-entry command queue sits between the decode front end and the
//   execution back end; the next command issues in the cycle the waiting
//   result is taken. When out_ready is low the result holds, the
//   back end stops and the queue fills, after which in_ready drops.
//   Reset (rst_n low, synchronous) clears the clock fields and counts,
//   marks every dose unused (hour 24), fills the match table with 2400 and
//   empties the queue; in_ready rises in the cycle after reset is released.
// ============================================================================
module dose_schedule_clock_keeper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsck_pkg::dsck_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dsck_pkg::dsck_out_t out_data
);

  dsck_pkg::dsck_qstat_t q_stat;
  dsck_pkg::dsck_cmd_t   push_cmd;
  dsck_pkg::dsck_cmd_t   pop_cmd;
  logic                  push;
  logic                  pop;

  dsck_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  dsck_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  dsck_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/dsck_checker.sv =====
// ============================================================================
// dsck_checker
// Port-level checks on the result channel of the clock keeper.
// ============================================================================
module dsck_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input dsck_pkg::dsck_out_t out_data
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only schedule entries may be non-final, and they carry nothing else.
  a_non_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |->
      out_data.field_value == 8'd0 && !out_data.remind && !out_data.missed_dose)
    else $error("non-final result carries field or flag data");

  // Reminder needs a match now, a missed dose needs none.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.remind && out_data.missed_dose))
    else $error("remind and missed_dose both set");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind dose_schedule_clock_keeper dsck_checker u_dsck_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
